/* hdl/mba_pkg.sv */
// ----------------------------------------------------------------------------
// mba_pkg
// Shared types and constants of the multichannel block averager: payload
// structs, register map, controller states and command/status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package mba_pkg;

  localparam int SAMPLE_W = 24;
  localparam int SUM_W    = 40;
  localparam int CNT_W    = 16;
  localparam int SPA_W    = 16;
  localparam int CHCFG_W  = 7;
  localparam int LIMIT_W  = 23;
  localparam int ROW_W    = 16;
  localparam int BLK_W    = 32;
  localparam int OUT_CH_W = 6;

  // divider retires two quotient bits per cycle
  localparam int DIV_BITS   = 2;
  localparam int DIV_ITERS  = SUM_W / DIV_BITS;
  localparam int DIV_CNT_W  = $clog2(DIV_ITERS);

  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  localparam logic [SPA_W-1:0]   SPA_RST   = 16'd10;
  localparam logic [CHCFG_W-1:0] CHANS_RST = 7'd8;
  localparam logic [LIMIT_W-1:0] LIMIT_RST = 23'd688128;

  typedef enum logic [1:0] {
    REG_SPA   = 2'd0,
    REG_CHANS = 2'd1,
    REG_LIMIT = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       not_a_number;
    logic                       start_run;
  } in_item_t;

  typedef struct packed {
    logic [OUT_CH_W-1:0]        channel;
    logic signed [SAMPLE_W-1:0] mean;
    logic [CNT_W-1:0]           valid_count;
    logic                       no_valid;
    logic [BLK_W-1:0]           block_number;
    logic                       last_channel;
  } out_item_t;

  typedef struct packed {
    logic [SPA_W-1:0]   samples_per_average;
    logic [CHCFG_W-1:0] channels_in_use;
    logic [LIMIT_W-1:0] valid_limit;
  } cfg_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [CNT_W-1:0]        count;
  } acc_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_READ   = 3'd1,
    ST_UPDATE = 3'd2,
    ST_DIV    = 3'd3,
    ST_EMIT   = 3'd4
  } mba_state_e;

  typedef struct packed {
    logic capture;   // take the input request
    logic rd;        // read channel accumulator
    logic upd;       // accumulate, write back or close block
    logic div_step;  // run one divider iteration
    logic emit;      // load the output register
  } dp_cmd_t;

  typedef struct packed {
    logic last_row;
    logic div_done;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

/* hdl/mba_regs.sv */
// ----------------------------------------------------------------------------
// mba_regs
// APB configuration registers: rows per average, channels in use and the
// sample magnitude limit.
// ----------------------------------------------------------------------------
`default_nettype none

module mba_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mba_pkg::APB_AW-1:0] paddr,
  input  logic [mba_pkg::APB_DW-1:0] pwdata,
  output logic [mba_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  output mba_pkg::cfg_t              cfg_o
);

  logic [mba_pkg::SPA_W-1:0]   spa_q;
  logic [mba_pkg::CHCFG_W-1:0] chans_q;
  logic [mba_pkg::LIMIT_W-1:0] limit_q;
  logic                        wr_en;
  mba_pkg::reg_idx_e           idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = mba_pkg::reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spa_q   <= mba_pkg::SPA_RST;
      chans_q <= mba_pkg::CHANS_RST;
      limit_q <= mba_pkg::LIMIT_RST;
    end else if (wr_en) begin
      case (idx)
        mba_pkg::REG_SPA:   spa_q   <= pwdata[mba_pkg::SPA_W-1:0];
        mba_pkg::REG_CHANS: chans_q <= pwdata[mba_pkg::CHCFG_W-1:0];
        mba_pkg::REG_LIMIT: limit_q <= pwdata[mba_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      mba_pkg::REG_SPA:   prdata = mba_pkg::APB_DW'(spa_q);
      mba_pkg::REG_CHANS: prdata = mba_pkg::APB_DW'(chans_q);
      mba_pkg::REG_LIMIT: prdata = mba_pkg::APB_DW'(limit_q);
      default:            prdata = '0;
    endcase
  end

  assign cfg_o.samples_per_average = spa_q;
  assign cfg_o.channels_in_use     = chans_q;
  assign cfg_o.valid_limit         = limit_q;

endmodule

`default_nettype wire

/* hdl/mba_ctrl.sv */
// ----------------------------------------------------------------------------
// mba_ctrl
// Controller: sequences capture, accumulator read, update, division and
// result hand-off for one request at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module mba_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  mba_pkg::dp_sts_t  sts_i,
  output mba_pkg::dp_cmd_t  cmd_o
);

  mba_pkg::mba_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mba_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      mba_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = mba_pkg::ST_READ;
      end
      mba_pkg::ST_READ: begin
        state_d = mba_pkg::ST_UPDATE;
      end
      mba_pkg::ST_UPDATE: begin
        state_d = sts_i.last_row ? mba_pkg::ST_DIV : mba_pkg::ST_IDLE;
      end
      mba_pkg::ST_DIV: begin
        if (sts_i.div_done) state_d = mba_pkg::ST_EMIT;
      end
      mba_pkg::ST_EMIT: begin
        if (sts_i.out_free) state_d = mba_pkg::ST_IDLE;
      end
      default: state_d = mba_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      mba_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      mba_pkg::ST_READ:   cmd_o.rd       = 1'b1;
      mba_pkg::ST_UPDATE: cmd_o.upd      = 1'b1;
      mba_pkg::ST_DIV:    cmd_o.div_step = 1'b1;
      mba_pkg::ST_EMIT:   cmd_o.emit     = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* hdl/mba_dp.sv */
// ----------------------------------------------------------------------------
// mba_dp
// Datapath: per-channel sum/count memory with valid bits, row and channel
// position counters, radix-4 restoring divider and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mba_dp #(
  parameter int MAX_CHANNELS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mba_pkg::cfg_t      cfg_i,
  input  mba_pkg::dp_cmd_t   cmd_i,
  input  mba_pkg::in_item_t  in_data_i,
  output mba_pkg::dp_sts_t   sts_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mba_pkg::out_item_t out_data_o
);

  localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int SUM_W = mba_pkg::SUM_W;
  localparam int CNT_W = mba_pkg::CNT_W;

  // accumulator memory, valid bits stand in for the cleared state
  mba_pkg::acc_t acc_mem [MAX_CHANNELS];
  logic [MAX_CHANNELS-1:0] vld_q;

  logic [CH_W-1:0]            pos_q;
  logic [mba_pkg::ROW_W-1:0]  row_q;
  logic [mba_pkg::BLK_W-1:0]  blk_q;

  mba_pkg::in_item_t item_q;
  mba_pkg::acc_t     rd_q;
  logic              ent_vld_q;

  // divider
  logic [SUM_W-1:0]               quo_q, quo_d;
  logic [CNT_W-1:0]               rem_q, rem_d;
  logic [CNT_W-1:0]               den_q;
  logic                           neg_q;
  logic [mba_pkg::DIV_CNT_W-1:0]  dcnt_q;

  // pending result fields
  logic [mba_pkg::OUT_CH_W-1:0]   res_ch_q;
  logic [mba_pkg::BLK_W-1:0]      res_blk_q;
  logic                           res_last_q;

  logic               out_vld_q;
  mba_pkg::out_item_t out_q;

  logic [CH_W-1:0]           chm1;
  logic [mba_pkg::ROW_W-1:0] rows_m1;
  logic                      last_row;
  logic                      last_ch;
  logic [SUM_W-1:0]          mag_sum;
  logic [mba_pkg::SAMPLE_W-1:0] mag_s;
  logic                      samp_ok;
  logic signed [SUM_W-1:0]   base_sum, new_sum;
  logic [CNT_W-1:0]          base_cnt, new_cnt;
  logic [SUM_W-1:0]          mean_full;

  // effective channel count minus one, clamped to the array size
  always_comb begin
    if (cfg_i.channels_in_use == '0) begin
      chm1 = '0;
    end else if (int'(cfg_i.channels_in_use) > MAX_CHANNELS) begin
      chm1 = CH_W'(MAX_CHANNELS - 1);
    end else begin
      chm1 = CH_W'(cfg_i.channels_in_use - 7'd1);
    end
  end

  assign rows_m1  = (cfg_i.samples_per_average == '0) ? '0 :
                    cfg_i.samples_per_average - 16'd1;
  assign last_row = row_q >= rows_m1;
  assign last_ch  = pos_q == chm1;

  // sample check and accumulate
  always_comb begin
    mag_s    = item_q.sample[mba_pkg::SAMPLE_W-1] ? -item_q.sample : item_q.sample;
    samp_ok  = !item_q.not_a_number && (mag_s < {1'b0, cfg_i.valid_limit});
    base_sum = ent_vld_q ? rd_q.sum : '0;
    base_cnt = ent_vld_q ? rd_q.count : '0;
    new_sum  = base_sum;
    new_cnt  = base_cnt;
    if (samp_ok) begin
      new_sum = base_sum + SUM_W'(item_q.sample);
      new_cnt = base_cnt + 16'd1;
    end
    mag_sum = new_sum[SUM_W-1] ? -new_sum : new_sum;
  end

  // two restoring steps per cycle
  always_comb begin
    logic [CNT_W:0] t;
    quo_d = quo_q;
    rem_d = rem_q;
    for (int i = 0; i < mba_pkg::DIV_BITS; i++) begin
      t     = {rem_d, quo_d[SUM_W-1]};
      quo_d = {quo_d[SUM_W-2:0], 1'b0};
      if (t >= {1'b0, den_q}) begin
        t        = t - {1'b0, den_q};
        quo_d[0] = 1'b1;
      end
      rem_d = t[CNT_W-1:0];
    end
  end

  assign mean_full = neg_q ? -quo_q : quo_q;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      pos_q     <= '0;
      row_q     <= '0;
      blk_q     <= '0;
      dcnt_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        if (in_data_i.start_run) begin
          vld_q <= '0;
          pos_q <= '0;
          row_q <= '0;
          blk_q <= '0;
        end else if (pos_q > chm1) begin
          pos_q <= '0;
        end
      end
      if (cmd_i.upd) begin
        vld_q[pos_q] <= !last_row;
        dcnt_q       <= '0;
        if (last_ch) begin
          pos_q <= '0;
          if (last_row) begin
            row_q <= '0;
            blk_q <= blk_q + 32'd1;
          end else begin
            row_q <= row_q + 16'd1;
          end
        end else begin
          pos_q <= pos_q + CH_W'(1);
        end
      end
      if (cmd_i.div_step) begin
        dcnt_q <= dcnt_q + mba_pkg::DIV_CNT_W'(1);
      end
      if (cmd_i.emit) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload and memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_data_i;
    end
    if (cmd_i.rd) begin
      rd_q      <= acc_mem[pos_q];
      ent_vld_q <= vld_q[pos_q];
    end
    if (cmd_i.upd) begin
      if (!last_row) begin
        acc_mem[pos_q] <= '{sum: new_sum, count: new_cnt};
      end else begin
        quo_q      <= mag_sum;
        rem_q      <= '0;
        den_q      <= new_cnt;
        neg_q      <= new_sum[SUM_W-1];
        res_ch_q   <= mba_pkg::OUT_CH_W'(pos_q);
        res_blk_q  <= blk_q;
        res_last_q <= last_ch;
      end
    end
    if (cmd_i.div_step) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
    if (cmd_i.emit) begin
      out_q.channel      <= res_ch_q;
      out_q.mean         <= (den_q == '0) ? '0 : mean_full[mba_pkg::SAMPLE_W-1:0];
      out_q.valid_count  <= den_q;
      out_q.no_valid     <= den_q == '0;
      out_q.block_number <= res_blk_q;
      out_q.last_channel <= res_last_q;
    end
  end

  assign sts_o.last_row = last_row;
  assign sts_o.div_done = dcnt_q == mba_pkg::DIV_CNT_W'(mba_pkg::DIV_ITERS - 1);
  assign sts_o.out_free = !out_vld_q || out_ready_i;

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

/* hdl/multichannel_block_averager.sv */
// ----------------------------------------------------------------------------
// multichannel_block_averager: per-channel decimating block mean
// A request without a result passes capture, memory read and update.
// A request closing a block also runs the 2-bit-per-cycle 40/16 divider and
// then loads the output register; it waits if that is full.
// Reset clears positions, block counter and accumulator valid bits at once.
// ----------------------------------------------------------------------------
`default_nettype none

module multichannel_block_averager #(
  parameter int MAX_CHANNELS = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  mba_pkg::in_item_t          in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output mba_pkg::out_item_t         out_data_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mba_pkg::APB_AW-1:0] paddr,
  input  logic [mba_pkg::APB_DW-1:0] pwdata,
  output logic [mba_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);

  mba_pkg::cfg_t    cfg;
  mba_pkg::dp_cmd_t cmd;
  mba_pkg::dp_sts_t sts;

  mba_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mba_dp #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .in_data_i   (in_data_i),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // one request in flight: no new request right after a capture
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while previous one in flight");

  // the accumulator update always uses freshly read memory data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.upd |-> $past(cmd.rd))
    else $error("update without preceding memory read");

  // a result only appears after the controller loaded it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.emit))
    else $error("result valid without emit");

endmodule

`default_nettype wire
